>>> src/chacha_pkg.sv
package chacha_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int ROUND_CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam int WORDS = 16;
    localparam int WORD_IDX_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2_3 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_4_5 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_6_7 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_0_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_2 = 3'd5;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = 4'd15;

    typedef logic [WORDS-1:0][31:0] state_t;

    typedef struct packed {
        logic load_init;
        logic do_round;
        logic diag;
        logic load_buf;
        logic shift_buf;
    } cmd_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } quarter_t;

    function automatic quarter_t qround(input logic [31:0] a_in, input logic [31:0] b_in,
                                        input logic [31:0] c_in, input logic [31:0] d_in);
        quarter_t q;
        logic [31:0] t;
        q.a = a_in + b_in;
        t = d_in ^ q.a;
        q.d = {t[15:0], t[31:16]};
        q.c = c_in + q.d;
        t = b_in ^ q.c;
        q.b = {t[19:0], t[31:20]};
        q.a = q.a + q.b;
        t = q.d ^ q.a;
        q.d = {t[23:0], t[31:24]};
        q.c = q.c + q.d;
        t = q.b ^ q.c;
        q.b = {t[24:0], t[31:25]};
        return q;
    endfunction

endpackage

>>> src/chacha_ctrl.sv
module chacha_ctrl
    import chacha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_IDX_W-1:0] word_index,
    output logic                  last_word,
    output cmd_t                  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [ROUND_CNT_W-1:0] round_cnt_reg, round_cnt_next;
    logic [WORD_IDX_W-1:0]  word_cnt_reg, word_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    logic accept;
    logic pop;
    logic buf_free;
    logic rounds_done;

    assign pop = out_valid_reg && out_ready;
    assign buf_free = !out_valid_reg || (pop && word_cnt_reg == LAST_WORD_IDX);
    assign rounds_done = round_cnt_reg == ROUND_CNT_W'(ROUNDS - 1);
    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_FINISH && buf_free);
    assign accept = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign word_index = word_cnt_reg;
    assign last_word = word_cnt_reg == LAST_WORD_IDX;

    assign cmd.load_init = accept;
    assign cmd.do_round = state_reg == ST_ROUND;
    assign cmd.diag = round_cnt_reg[0];
    assign cmd.load_buf = state_reg == ST_FINISH && buf_free;
    assign cmd.shift_buf = pop;

    always_comb
    begin
        state_next = state_reg;
        round_cnt_next = round_cnt_reg;
        word_cnt_next = word_cnt_reg;
        out_valid_next = out_valid_reg;

        if (pop)
        begin
            word_cnt_next = word_cnt_reg + 1'b1;
            if (word_cnt_reg == LAST_WORD_IDX)
            begin
                out_valid_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ROUND;
                    round_cnt_next = '0;
                end
            end
            ST_ROUND:
            begin
                if (rounds_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    round_cnt_next = round_cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (buf_free)
                begin
                    out_valid_next = 1'b1;
                    word_cnt_next = '0;
                    if (accept)
                    begin
                        state_next = ST_ROUND;
                        round_cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_cnt_reg <= '0;
            word_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_cnt_reg <= round_cnt_next;
            word_cnt_reg <= word_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/chacha_dp.sv
module chacha_dp
    import chacha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [31:0]           block_counter,
    input  cmd_t                  cmd,
    output logic [31:0]           keystream_word
);

    logic [63:0] key01_reg;
    logic [63:0] key23_reg;
    logic [63:0] key45_reg;
    logic [63:0] key67_reg;
    logic [63:0] nonce01_reg;
    logic [31:0] nonce2_reg;

    logic [31:0] counter_reg;
    state_t      work_reg, work_next;
    state_t      buf_reg, buf_next;
    state_t      round_out;
    state_t      init_new;
    state_t      init_cur;

    function automatic state_t make_init(input logic [31:0] ctr, input logic [63:0] k01,
                                         input logic [63:0] k23, input logic [63:0] k45,
                                         input logic [63:0] k67, input logic [63:0] n01,
                                         input logic [31:0] n2);
        state_t s;
        s[0] = SIGMA_0;
        s[1] = SIGMA_1;
        s[2] = SIGMA_2;
        s[3] = SIGMA_3;
        s[4] = k01[31:0];
        s[5] = k01[63:32];
        s[6] = k23[31:0];
        s[7] = k23[63:32];
        s[8] = k45[31:0];
        s[9] = k45[63:32];
        s[10] = k67[31:0];
        s[11] = k67[63:32];
        s[12] = ctr;
        s[13] = n01[31:0];
        s[14] = n01[63:32];
        s[15] = n2;
        return s;
    endfunction

    assign init_new = make_init(block_counter, key01_reg, key23_reg, key45_reg, key67_reg,
                                nonce01_reg, nonce2_reg);
    assign init_cur = make_init(counter_reg, key01_reg, key23_reg, key45_reg, key67_reg,
                                nonce01_reg, nonce2_reg);

    // A diagonal round is a column round on rows one to three rotated by their row number.
    always_comb
    begin
        logic [1:0] ib;
        logic [1:0] ic;
        logic [1:0] id;
        quarter_t   q;
        round_out = work_reg;
        for (int j = 0; j < 4; j++)
        begin
            ib = 2'(j) + {1'b0, cmd.diag};
            ic = 2'(j) + {cmd.diag, 1'b0};
            id = 2'(j) + {cmd.diag, cmd.diag};
            q = qround(work_reg[4'(j)], work_reg[{2'b01, ib}],
                       work_reg[{2'b10, ic}], work_reg[{2'b11, id}]);
            round_out[4'(j)] = q.a;
            round_out[{2'b01, ib}] = q.b;
            round_out[{2'b10, ic}] = q.c;
            round_out[{2'b11, id}] = q.d;
        end
    end

    always_comb
    begin
        work_next = work_reg;
        if (cmd.load_init)
        begin
            work_next = init_new;
        end
        else if (cmd.do_round)
        begin
            work_next = round_out;
        end
    end

    always_comb
    begin
        buf_next = buf_reg;
        if (cmd.load_buf)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                buf_next[i] = work_reg[i] + init_cur[i];
            end
        end
        else if (cmd.shift_buf)
        begin
            buf_next = buf_reg >> 32;
        end
    end

    assign keystream_word = buf_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg <= '0;
            key23_reg <= '0;
            key45_reg <= '0;
            key67_reg <= '0;
            nonce01_reg <= '0;
            nonce2_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_0_1:   key01_reg <= cfg_data;
                REG_KEY_2_3:   key23_reg <= cfg_data;
                REG_KEY_4_5:   key45_reg <= cfg_data;
                REG_KEY_6_7:   key67_reg <= cfg_data;
                REG_NONCE_0_1: nonce01_reg <= cfg_data;
                REG_NONCE_2:   nonce2_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_init)
        begin
            counter_reg <= block_counter;
        end
        work_reg <= work_next;
        buf_reg <= buf_next;
    end

endmodule

>>> src/chacha20_keystream_block_core.sv
// Produces one 64-byte ChaCha20 keystream block per accepted block counter, using the key and
// nonce held in the configuration registers, and streams it as sixteen 32-bit words, word 0
// first, each to be serialised little-endian. The counter beat loads the initial state, the
// rounds then run one per cycle through four parallel mixing lanes, and a final step adds the
// initial state into the output buffer, from which the first word is presented. The next
// counter can be taken in the same cycle as that final addition, so a counter is taken while
// the previous block is still being streamed out; the final addition, and with it the
// following counter beat, waits until the consumer has taken the last word of the previous
// block. Configuration must be written only while no block is in flight; the block itself
// does not enforce this.
module chacha20_keystream_block_core
    import chacha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           block_counter,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           keystream_word,
    output logic [WORD_IDX_W-1:0] word_index,
    output logic                  last_word
);

    cmd_t cmd;

    chacha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .last_word  (last_word),
        .cmd        (cmd)
    );

    chacha_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .block_counter  (block_counter),
        .cmd            (cmd),
        .keystream_word (keystream_word)
    );

endmodule

>>> src/chacha_chk.sv
module chacha_chk
    import chacha_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [31:0]           block_counter,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [31:0]           keystream_word,
    input logic [WORD_IDX_W-1:0] word_index,
    input logic                  last_word
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(keystream_word) && $stable(word_index))
        else $error("output beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && word_index == $past(word_index) + 1'b1)
        else $error("word sequence broken within a block");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_word == (word_index == LAST_WORD_IDX))
        else $error("last word flag disagrees with word index");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("counter beat taken while rounds are running");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(block_counter))
        else $error("counter beat withdrawn or changed while waiting");

endmodule

bind chacha20_keystream_block_core chacha_chk u_chk (.*);
